// ===== sv/cfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpm_pkg
// Shared types, constants and helpers for the case-folded pattern matcher.
// ----------------------------------------------------------------------------
package cfpm_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int WIN_DEPTH   = 2 * MAX_PATTERN;
  localparam int IDX_W       = $clog2(WIN_DEPTH);
  localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int ADDR_W      = 48;
  localparam int PAT_W       = 64;
  localparam int PAT_BYTES   = PAT_W / 8;
  localparam int LEN_W       = 4;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES = 2'd0,
    CFG_PATTERN_LEN   = 2'd1,
    CFG_WIDE_ENABLE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PAT_W-1:0] pattern_bytes;
    logic [LEN_W-1:0] pattern_len;
    logic             wide_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              chunk_end;
  } in_req_t;

  typedef struct packed {
    logic              narrow_hit;
    logic [ADDR_W-1:0] narrow_start;
    logic              wide_hit;
    logic [ADDR_W-1:0] wide_start;
  } out_res_t;

  // Window stage handed to the compare stage; entry 0 is the newest byte
  typedef struct packed {
    logic                       valid;
    logic [WIN_DEPTH-1:0][7:0]  window;
    logic [FILL_W-1:0]          fill;
    logic                       phase;
    logic [ADDR_W-1:0]          byte_address;
  } stage_t;

  // Fold A-Z to lower case, leave every other byte alone
  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

// ===== sv/case_folded_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// case_folded_pattern_matcher
// Case-insensitive search of a byte stream for one pattern, ANSI and UTF-16LE.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one memory byte per request with its address and a chunk-end mark.
//   out_* : one result per input byte, in byte order: an ANSI hit and an
//           aligned UTF-16LE hit, each with the start address of the match.
//   cfg_* : write pattern bytes (index 0), pattern length (1) and the wide
//           search enable (2) while no request is in flight; other indexes
//           are ignored.
// Timing:
//   A byte taken is registered in the window stage and then in the output
//   register. The window register and the compare stage each hold one
//   request, so one byte is taken every cycle while out_stall is low.
// Reset:
//   The window, fill count and phase start as after a chunk end; the
//   registers return to pattern 0, length 8 and wide search enabled.
// Stall:
//   While out_stall holds a result, the compare stage holds too and in_stall
//   rises once the window stage is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module case_folded_pattern_matcher (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cfpm_pkg::in_req_t                   in_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cfpm_pkg::out_res_t                  out_res,
  input  logic                                cfg_we,
  input  logic [cfpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfpm_pkg::PAT_W-1:0]          cfg_wdata
);

  cfpm_pkg::cfg_t   cfg_r;
  cfpm_pkg::stage_t stage;
  logic             adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes <= '0;
      cfg_r.pattern_len   <= cfpm_pkg::LEN_W'(cfpm_pkg::MAX_PATTERN);
      cfg_r.wide_enable   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfpm_pkg::CFG_PATTERN_BYTES: cfg_r.pattern_bytes <= cfg_wdata;
        cfpm_pkg::CFG_PATTERN_LEN:   cfg_r.pattern_len   <= cfg_wdata[cfpm_pkg::LEN_W-1:0];
        cfpm_pkg::CFG_WIDE_ENABLE:   cfg_r.wide_enable   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  cfpm_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .adv      (adv),
    .stage    (stage)
  );

  cfpm_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .stage     (stage),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule

// ===== sv/cfpm_window.sv =====
// ----------------------------------------------------------------------------
// cfpm_window
// Input register stage: shifts each accepted byte into the chunk window and
// holds the window, fill count, phase and address for the compare stage.
// ----------------------------------------------------------------------------
module cfpm_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cfpm_pkg::in_req_t in_req,
  input  logic              adv,
  output cfpm_pkg::stage_t  stage
);

  logic                                       valid_r;
  logic                                       valid_nxt;
  logic                                       clear_pending_r;
  logic [cfpm_pkg::WIN_DEPTH-1:0][7:0]        win_r;
  logic [cfpm_pkg::WIN_DEPTH-1:0][7:0]        win_nxt;
  logic [cfpm_pkg::WIN_DEPTH-1:0][7:0]        win_base;
  logic [cfpm_pkg::FILL_W-1:0]                fill_r;
  logic [cfpm_pkg::FILL_W-1:0]                fill_nxt;
  logic [cfpm_pkg::FILL_W-1:0]                fill_base;
  logic                                       phase_r;
  logic                                       phase_nxt;
  logic [cfpm_pkg::ADDR_W-1:0]                addr_r;
  logic                                       accept;

  // Stall only while a held request cannot move on
  assign in_stall = valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  // Shift in the new byte; start afresh after a chunk end or reset
  always_comb begin
    win_base  = clear_pending_r ? '0 : win_r;
    fill_base = clear_pending_r ? '0 : fill_r;
    win_nxt[0] = in_req.data_byte;
    for (int i = 1; i < cfpm_pkg::WIN_DEPTH; i++) begin
      win_nxt[i] = win_base[i-1];
    end
    if (fill_base < cfpm_pkg::FILL_W'(cfpm_pkg::WIN_DEPTH)) begin
      fill_nxt = fill_base + cfpm_pkg::FILL_W'(1);
    end else begin
      fill_nxt = fill_base;
    end
    phase_nxt = clear_pending_r ? 1'b0 : !phase_r;
  end

  // Stage occupancy
  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r         <= 1'b0;
      clear_pending_r <= 1'b1;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        clear_pending_r <= in_req.chunk_end;
      end
    end
  end

  // Payload: load on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      phase_r <= phase_nxt;
      addr_r  <= in_req.byte_address;
    end
  end

  assign stage.valid        = valid_r;
  assign stage.window       = win_r;
  assign stage.fill         = fill_r;
  assign stage.phase        = phase_r;
  assign stage.byte_address = addr_r;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (fill_r != '0 && fill_r <= cfpm_pkg::FILL_W'(cfpm_pkg::WIN_DEPTH)))
    else $error("fill count out of range");
  a_chunk_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.chunk_end) |=> clear_pending_r)
    else $error("chunk end did not arm window clear");
  a_first_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && clear_pending_r) |=> (fill_r == cfpm_pkg::FILL_W'(1) && !phase_r))
    else $error("chunk start not restarted");
`endif

endmodule

// ===== sv/cfpm_match.sv =====
// ----------------------------------------------------------------------------
// cfpm_match
// Compare stage: matches the window against the folded pattern as ANSI and
// as aligned UTF-16LE, and holds the outcome in the result register.
// ----------------------------------------------------------------------------
module cfpm_match (
  input  logic               clk,
  input  logic               rst_n,
  input  cfpm_pkg::cfg_t     cfg,
  input  cfpm_pkg::stage_t   stage,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_stall,
  output cfpm_pkg::out_res_t out_res
);

  logic [cfpm_pkg::LEN_W-1:0]  len;
  logic [cfpm_pkg::IDX_W:0]    len_x;
  logic [cfpm_pkg::FILL_W:0]   fill_x;
  logic [cfpm_pkg::IDX_W:0]    n_idx;
  logic [cfpm_pkg::IDX_W:0]    lo_idx;
  logic [cfpm_pkg::IDX_W:0]    hi_idx;
  logic [7:0]                  pat_c;
  logic                        n_ok;
  logic                        w_ok;
  cfpm_pkg::out_res_t          res_nxt;
  cfpm_pkg::out_res_t          res_r;
  logic                        valid_r;

  // Result register moves when empty or when its request is taken
  assign adv = !valid_r || !out_stall;

  // Saturate the pattern length
  always_comb begin
    if (cfg.pattern_len > cfpm_pkg::LEN_W'(cfpm_pkg::MAX_PATTERN)) begin
      len = cfpm_pkg::LEN_W'(cfpm_pkg::MAX_PATTERN);
    end else begin
      len = cfg.pattern_len;
    end
    len_x  = (cfpm_pkg::IDX_W+1)'(len);
    fill_x = (cfpm_pkg::FILL_W+1)'(stage.fill);
  end

  // Per-character compare, one lane per pattern position
  always_comb begin
    n_ok = (len != '0) && (fill_x >= (cfpm_pkg::FILL_W+1)'(len));
    w_ok = (len != '0) && cfg.wide_enable && stage.phase &&
           (fill_x >= (cfpm_pkg::FILL_W+1)'({len, 1'b0}));
    n_idx  = '0;
    lo_idx = '0;
    hi_idx = '0;
    pat_c  = '0;
    for (int j = 0; j < cfpm_pkg::MAX_PATTERN; j++) begin
      if (j < cfpm_pkg::PAT_BYTES) begin
        pat_c = cfpm_pkg::fold(cfg.pattern_bytes[8*j +: 8]);
      end else begin
        pat_c = '0;
      end
      if ((cfpm_pkg::IDX_W+1)'(j) < len_x) begin
        n_idx  = len_x - (cfpm_pkg::IDX_W+1)'(1) - (cfpm_pkg::IDX_W+1)'(j);
        lo_idx = {len_x[cfpm_pkg::IDX_W-1:0], 1'b0} - (cfpm_pkg::IDX_W+1)'(1)
                 - (cfpm_pkg::IDX_W+1)'(2 * j);
        hi_idx = {len_x[cfpm_pkg::IDX_W-1:0], 1'b0} - (cfpm_pkg::IDX_W+1)'(2)
                 - (cfpm_pkg::IDX_W+1)'(2 * j);
        if (cfpm_pkg::fold(stage.window[n_idx[cfpm_pkg::IDX_W-1:0]]) != pat_c) begin
          n_ok = 1'b0;
        end
        if (stage.window[hi_idx[cfpm_pkg::IDX_W-1:0]] != 8'h00 ||
            cfpm_pkg::fold(stage.window[lo_idx[cfpm_pkg::IDX_W-1:0]]) != pat_c) begin
          w_ok = 1'b0;
        end
      end
    end
  end

  // Start addresses, zero when there is no hit
  always_comb begin
    res_nxt.narrow_hit   = n_ok;
    res_nxt.narrow_start = n_ok ? (stage.byte_address + cfpm_pkg::ADDR_W'(1)
                                   - cfpm_pkg::ADDR_W'(len)) : '0;
    res_nxt.wide_hit     = w_ok;
    res_nxt.wide_start   = w_ok ? (stage.byte_address + cfpm_pkg::ADDR_W'(1)
                                   - cfpm_pkg::ADDR_W'({len, 1'b0})) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && stage.valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

`ifndef SYNTHESIS
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stage.valid && cfg.pattern_len == '0) |=> (!res_r.narrow_hit && !res_r.wide_hit))
    else $error("hit reported with zero pattern length");
  a_wide_off: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stage.valid && !cfg.wide_enable) |=> !res_r.wide_hit)
    else $error("wide hit while wide search disabled");
  a_wide_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stage.valid && !stage.phase) |=> !res_r.wide_hit)
    else $error("wide hit on an even byte");
`endif

endmodule

// ===== dv/case_folded_pattern_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// case_folded_pattern_matcher_tb
// Self-checking bench for the case-folded pattern matcher. A scoreboard keeps
// its own byte window, fill count and chunk phase, works out the ANSI and
// UTF-16LE hits for every accepted byte and checks each result in order.
// Stimulus is a short directed run, then chunks holding the pattern in either
// encoding with random case, broken and truncated copies, and plain noise,
// over a series of register settings. Both sides idle at random.
// ----------------------------------------------------------------------------

class hit_scoreboard;

  logic [cfpm_pkg::PAT_W-1:0] pattern;
  logic [cfpm_pkg::LEN_W-1:0] pat_len;
  bit                         wide_on;
  logic [7:0]                 window [cfpm_pkg::WIN_DEPTH];
  int                         filled;
  bit                         odd_next;
  cfpm_pkg::out_res_t         hits_due [$];
  int                         bad_results;

  function new();
    pattern     = '0;
    pat_len     = 4'd8;
    wide_on     = 1'b1;
    bad_results = 0;
    clear_window();
  endfunction

  function void clear_window();
    foreach (window[i]) window[i] = 8'h00;
    filled   = 0;
    odd_next = 1'b0;
  endfunction

  function int pending();
    return hits_due.size();
  endfunction

  // Mirror a register write; unknown indexes are dropped
  function void write_reg(input logic [cfpm_pkg::CFG_IDX_W-1:0] idx,
                          input logic [cfpm_pkg::PAT_W-1:0] value);
    case (idx)
      cfpm_pkg::CFG_PATTERN_BYTES: pattern = value;
      cfpm_pkg::CFG_PATTERN_LEN:   pat_len = value[cfpm_pkg::LEN_W-1:0];
      cfpm_pkg::CFG_WIDE_ENABLE:   wide_on = value[0];
      default: ;
    endcase
  endfunction

  static function logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
  endfunction

  // Take one byte into the window and queue the hits it completes
  function void note_request(input cfpm_pkg::in_req_t req);
    cfpm_pkg::out_res_t          due;
    logic [cfpm_pkg::ADDR_W-1:0] span;
    int                          l;
    int                          i;
    int                          j;
    bit                          was_odd;
    bit                          narrow;
    bit                          wide;
    l       = (pat_len > cfpm_pkg::MAX_PATTERN) ? cfpm_pkg::MAX_PATTERN : int'(pat_len);
    was_odd = odd_next;
    for (i = cfpm_pkg::WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = req.data_byte;
    if (filled < cfpm_pkg::WIN_DEPTH) filled++;

    // ANSI: newest l bytes, oldest first
    narrow = (l != 0) && (filled >= l);
    for (j = 0; j < l; j++) begin
      if (to_lower(window[l-1-j]) != to_lower(pattern[8*j +: 8])) narrow = 1'b0;
    end

    // UTF-16LE: low byte then zero high byte, ending on an odd offset
    wide = wide_on && was_odd && (l != 0) && (filled >= 2 * l);
    for (j = 0; j < l; j++) begin
      if (window[2*l-2-2*j] != 8'h00 ||
          to_lower(window[2*l-1-2*j]) != to_lower(pattern[8*j +: 8])) wide = 1'b0;
    end

    due = '0;
    if (narrow) begin
      span              = cfpm_pkg::ADDR_W'(l - 1);
      due.narrow_hit    = 1'b1;
      due.narrow_start  = req.byte_address - span;
    end
    if (wide) begin
      span            = cfpm_pkg::ADDR_W'(2 * l - 1);
      due.wide_hit    = 1'b1;
      due.wide_start  = req.byte_address - span;
    end
    hits_due.insert(hits_due.size(), due);

    odd_next = !was_odd;
    if (req.chunk_end) clear_window();
  endfunction

  // Compare one result with the oldest expectation
  function void check_result(input cfpm_pkg::out_res_t got);
    cfpm_pkg::out_res_t due;
    if (hits_due.size() == 0) begin
      bad_results++;
      if (bad_results <= 10) begin
        $display("%0t: result with nothing outstanding: narrow %0b/%h wide %0b/%h",
                 $time, got.narrow_hit, got.narrow_start, got.wide_hit, got.wide_start);
      end
      return;
    end
    due = hits_due.pop_front();
    if (got.narrow_hit !== due.narrow_hit || got.narrow_start !== due.narrow_start ||
        got.wide_hit !== due.wide_hit || got.wide_start !== due.wide_start) begin
      bad_results++;
      if (bad_results <= 10) begin
        $display("%0t: got narrow %0b/%h wide %0b/%h, want narrow %0b/%h wide %0b/%h",
                 $time, got.narrow_hit, got.narrow_start, got.wide_hit, got.wide_start,
                 due.narrow_hit, due.narrow_start, due.wide_hit, due.wide_start);
      end
    end
  endfunction

endclass

module case_folded_pattern_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [cfpm_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int STALL_PCT      = 15;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 60;

  typedef enum int {
    CHUNK_NARROW,
    CHUNK_WIDE,
    CHUNK_BROKEN,
    CHUNK_CUT,
    CHUNK_LONG,
    CHUNK_NOISE
  } chunk_kind_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  cfpm_pkg::in_req_t              in_req    = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  cfpm_pkg::out_res_t             out_res;
  logic                           cfg_we    = 1'b0;
  logic [cfpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cfpm_pkg::PAT_W-1:0]     cfg_wdata = '0;

  hit_scoreboard                  hits = new();
  bit                             calm = 1'b0;
  logic [cfpm_pkg::ADDR_W-1:0]    cursor = '0;
  logic [cfpm_pkg::PAT_W-1:0]     cur_pattern = '0;
  logic [cfpm_pkg::LEN_W-1:0]     cur_len = 4'd8;
  logic [7:0]                     chunk_q [$];
  int                             idle_cycles = 0;
  int                             sent = 0;

  case_folded_pattern_matcher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random, except in the calm phase
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      hits.check_result(out_res);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("case_folded_pattern_matcher: mismatch");
      $finish;
    end
  end

  function automatic logic [cfpm_pkg::ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[cfpm_pkg::ADDR_W-1:0];
  endfunction

  function automatic int embed_len();
    if (cur_len == 0 || cur_len > cfpm_pkg::MAX_PATTERN) return cfpm_pkg::MAX_PATTERN;
    return int'(cur_len);
  endfunction

  // Append one byte to the chunk under construction
  function automatic void append_byte(input logic [7:0] b);
    chunk_q.insert(chunk_q.size(), b);
  endfunction

  // Pattern character j with its case picked at random
  function automatic logic [7:0] pat_byte(input int j);
    logic [7:0] c;
    c = cur_pattern[8*j +: 8];
    if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
      c = $urandom_range(0, 1) ? (c | 8'h20) : (c & 8'hDF);
    end else if (c[7] && $urandom_range(0, 3) == 0) begin
      c = c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0, 1:    return pat_byte(int'($urandom_range(0, embed_len() - 1)));
      2:       return 8'h00;
      3:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [cfpm_pkg::PAT_W-1:0] random_pattern();
    logic [cfpm_pkg::PAT_W-1:0] p;
    int                         j;
    for (j = 0; j < cfpm_pkg::PAT_BYTES; j++) begin
      case ($urandom_range(0, 9))
        6, 7:    p[8*j +: 8] = 8'($urandom_range(0, 255));
        8:       p[8*j +: 8] = 8'h80 | 8'($urandom_range(0, 127));
        9:       p[8*j +: 8] = 8'h00;
        default: p[8*j +: 8] = (8'h41 + 8'($urandom_range(0, 25))) |
                               8'($urandom_range(0, 1) << 5);
      endcase
    end
    return p;
  endfunction

  function automatic void add_narrow(input int count);
    int j;
    for (j = 0; j < count; j++) append_byte(pat_byte(j));
  endfunction

  // Wide copy, on an even offset when aligned, otherwise on an odd one
  function automatic void add_wide(input int count, input bit aligned);
    int j;
    if ((chunk_q.size() % 2 != 0) == aligned) append_byte(noise_byte());
    for (j = 0; j < count; j++) begin
      append_byte(pat_byte(j));
      append_byte(8'h00);
    end
  endfunction

  function automatic void build_chunk(input chunk_kind_t kind);
    int l;
    int spot;
    l = embed_len();
    chunk_q.delete();
    repeat ($urandom_range(0, 5)) append_byte(noise_byte());
    case (kind)
      CHUNK_NARROW: add_narrow(l);
      CHUNK_WIDE:   add_wide(l, 1'b1);
      CHUNK_BROKEN: begin
        // flip one bit somewhere in or before the copy
        if ($urandom_range(0, 1)) add_narrow(l);
        else add_wide(l, $urandom_range(0, 3) != 0);
        spot = int'($urandom_range(0, chunk_q.size() - 1));
        chunk_q[spot] = chunk_q[spot] ^ (8'h01 << $urandom_range(0, 7));
      end
      CHUNK_CUT: begin
        // end the chunk inside the copy
        if ($urandom_range(0, 1)) add_narrow(int'($urandom_range(1, l)));
        else add_wide(int'($urandom_range(1, l)), 1'b1);
      end
      CHUNK_LONG: begin
        repeat ($urandom_range(2, 4)) begin
          if ($urandom_range(0, 1)) add_narrow(l);
          else add_wide(l, 1'b1);
          repeat ($urandom_range(0, 4)) append_byte(noise_byte());
        end
      end
      default: repeat ($urandom_range(1, 20)) append_byte(noise_byte());
    endcase
    if (kind != CHUNK_CUT) begin
      repeat ($urandom_range(0, 4)) append_byte(noise_byte());
    end
    if (chunk_q.size() == 0) append_byte(noise_byte());
  endfunction

  // Offer one byte at the cursor and hold it until taken
  task automatic send_byte(input logic [7:0] data, input logic last);
    cfpm_pkg::in_req_t req;
    req.data_byte    = data;
    req.byte_address = cursor;
    req.chunk_end    = last;
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hits.note_request(req);
    cursor = cursor + cfpm_pkg::ADDR_W'(1);
    sent++;
  endtask

  task automatic send_chunk();
    int i;
    for (i = 0; i < chunk_q.size(); i++) begin
      send_byte(chunk_q[i], i == chunk_q.size() - 1);
      // now and then jump the address mid-chunk
      if ($urandom_range(0, 39) == 0) cursor = rand_addr();
    end
  endtask

  // Drop valid and hold until every queued result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (hits.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cfpm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cfpm_pkg::PAT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    hits.write_reg(idx, value);
  endtask

  task automatic configure(input logic [cfpm_pkg::PAT_W-1:0] pattern,
                           input logic [cfpm_pkg::LEN_W-1:0] len,
                           input logic wide, input bit spare);
    write_reg(cfpm_pkg::CFG_PATTERN_BYTES, pattern);
    write_reg(cfpm_pkg::CFG_PATTERN_LEN, cfpm_pkg::PAT_W'(len));
    write_reg(cfpm_pkg::CFG_WIDE_ENABLE, cfpm_pkg::PAT_W'(wide));
    if (spare) write_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
    cfg_we      <= 1'b0;
    cur_pattern = pattern;
    cur_len     = len;
  endtask

  task automatic run_phase(input int items);
    int stop;
    stop = sent + items;
    while (sent < stop) begin
      build_chunk(chunk_kind_t'($urandom_range(0, 5)));
      if ($urandom_range(0, 7) == 0) cursor = rand_addr();
      send_chunk();
    end
  endtask

  initial begin
    logic [cfpm_pkg::PAT_W-1:0] p;
    int                         i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings match zeros: a zero chunk across the address wrap
    cursor = 48'hFFFF_FFFF_FFF8;
    for (i = 0; i < 16; i++) send_byte(8'h00, i == 15);
    cursor = '1;
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    wait_drained();

    configure(random_pattern(), 4'd5, 1'b1, 1'b0);
    run_phase(PHASE_ITEMS);
    wait_drained();

    // Zero length: nothing may hit
    configure(random_pattern(), 4'd0, 1'b1, 1'b0);
    run_phase(PHASE_ITEMS / 2);
    wait_drained();

    // Overlong length with bytes above 0x7F, no idling on either side
    p = random_pattern();
    p[15:8]  = 8'hC1;
    p[47:40] = 8'h80 | 8'($urandom_range(0, 127));
    calm <= 1'b1;
    configure(p, 4'd15, 1'b1, 1'b0);
    run_phase(PHASE_ITEMS);
    wait_drained();
    calm <= 1'b0;

    // All-ones pattern, wide search off, write to the unused index
    configure('1, 4'd8, 1'b0, 1'b1);
    run_phase(PHASE_ITEMS);
    wait_drained();

    // Short repetitive pattern for overlapping hits
    configure(64'h4161_4161_4161_4161, 4'd3, 1'b1, 1'b0);
    run_phase(PHASE_ITEMS);
    wait_drained();

    configure(random_pattern(), 4'd1, 1'b1, 1'b0);
    run_phase(PHASE_ITEMS);
    wait_drained();

    // Zero pattern with a length just over the maximum
    configure('0, 4'd9, 1'b1, 1'b0);
    run_phase(PHASE_ITEMS);
    wait_drained();

    repeat (4) begin
      configure(random_pattern(), cfpm_pkg::LEN_W'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (hits.bad_results == 0 && hits.pending() == 0) begin
      $display("case_folded_pattern_matcher: match");
    end else begin
      $display("case_folded_pattern_matcher: mismatch");
    end
    $finish;
  end

endmodule

// ===== case_folded_pattern_matcher.f =====
sv/cfpm_pkg.sv
sv/cfpm_window.sv
sv/cfpm_match.sv
sv/case_folded_pattern_matcher.sv
dv/case_folded_pattern_matcher_tb.sv
